>>> hw/rtl/optical_property_combiner_defines.svh
// Assertion macros shared by the optical property combiner checkers.
`ifndef OPTICAL_PROPERTY_COMBINER_DEFINES_SVH
`define OPTICAL_PROPERTY_COMBINER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define OPC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("optical_property_combiner: assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define OPC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("optical_property_combiner: assertion failed");

`endif

>>> hw/rtl/opc_pkg.sv
// Types and constants shared by the optical property combiner modules.
`timescale 1ns / 1ps
`default_nettype none

package opc_pkg;

    localparam int DEPTH_IN_W   = 24;
    localparam int ALBEDO_W     = 17;
    localparam int ASYM_W       = 17;
    localparam int SCAT_TERM_W  = 25;
    localparam int DEPTH_SUM_W  = 28;
    localparam int SCAT_SUM_W   = 29;
    localparam int WASYM_W      = 48;
    localparam int MUL_A_W      = 26;
    localparam int MUL_B_W      = 18;
    localparam int MUL_P_W      = 44;
    localparam int REM_W        = 32;
    localparam int QUO_W        = 17;
    localparam int DIV_CNT_W    = 5;
    localparam int TDATA_W      = 64;
    localparam int STATUS_W     = 2;

    localparam logic [DEPTH_SUM_W-1:0] DEPTH_SUM_MAX = 28'h0FFFFFF | 28'hF000000;
    localparam logic [SCAT_SUM_W-1:0]  SCAT_SUM_MAX  = 29'h1FFFFFFF;
    localparam logic [WASYM_W-1:0]     WASYM_MAX     = 48'h7FFF_FFFF_FFFF;
    localparam logic [WASYM_W-1:0]     WASYM_MIN     = 48'h8000_0000_0000;
    localparam logic [DEPTH_IN_W-1:0]  OUT_DEPTH_MAX = 24'hFFFFFF;
    localparam logic [QUO_W-1:0]       ALBEDO_ONE    = 17'd65536;
    localparam logic [QUO_W-1:0]       ASYM_ONE      = 17'd32768;
    localparam logic [DIV_CNT_W-1:0]   ALB_QUO_BITS  = 5'd17;
    localparam logic [DIV_CNT_W-1:0]   ASYM_QUO_BITS = 5'd16;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK           = 2'd0,
        ST_ZERO_DEPTH   = 2'd1,
        ST_ZERO_SCATTER = 2'd2,
        ST_DEPTH_SAT    = 2'd3
    } status_t;

    typedef struct packed {
        logic add;
        logic clear;
    } acc_ctl_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_CNT_W-1:0] nbits;
    } div_ctl_t;

    typedef struct packed {
        logic done;
        logic overflow;
    } div_stat_t;

endpackage

`default_nettype wire

>>> hw/rtl/opc_mult.sv
// Shared signed multiplier with a registered product.
`timescale 1ns / 1ps
`default_nettype none

module opc_mult (
    input  wire logic                                clk,
    input  wire logic                                load,
    input  wire logic signed [opc_pkg::MUL_A_W-1:0]  a,
    input  wire logic signed [opc_pkg::MUL_B_W-1:0]  b,
    output logic signed      [opc_pkg::MUL_P_W-1:0]  product
);

    logic signed [opc_pkg::MUL_P_W-1:0] product_reg;
    logic signed [opc_pkg::MUL_P_W-1:0] product_next;

    assign product_next = opc_pkg::MUL_P_W'(a) * opc_pkg::MUL_P_W'(b);

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            product_reg <= product_next;
        end
    end

    assign product = product_reg;

endmodule

`default_nettype wire

>>> hw/rtl/opc_accum.sv
// Saturating accumulators for depth, scattering depth and weighted asymmetry.
`timescale 1ns / 1ps
`default_nettype none

module opc_accum (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire opc_pkg::acc_ctl_t                      ctl,
    input  wire logic        [opc_pkg::DEPTH_IN_W-1:0]  depth_in,
    input  wire logic        [opc_pkg::SCAT_TERM_W-1:0] scatter_in,
    input  wire logic signed [opc_pkg::MUL_P_W-1:0]     wterm_in,
    output logic             [opc_pkg::DEPTH_SUM_W-1:0] depth_sum,
    output logic             [opc_pkg::SCAT_SUM_W-1:0]  scatter_sum,
    output logic signed      [opc_pkg::WASYM_W-1:0]     wasym_sum
);

    logic [opc_pkg::DEPTH_SUM_W-1:0] depth_reg, depth_next;
    logic [opc_pkg::SCAT_SUM_W-1:0]  scat_reg, scat_next;
    logic [opc_pkg::WASYM_W-1:0]     wasym_reg, wasym_next;

    logic [opc_pkg::DEPTH_SUM_W:0]   depth_add;
    logic [opc_pkg::SCAT_SUM_W:0]    scat_add;
    logic [opc_pkg::WASYM_W:0]       wasym_add;

    always_comb
    begin
        depth_add = {1'b0, depth_reg} + (opc_pkg::DEPTH_SUM_W + 1)'(depth_in);
        scat_add  = {1'b0, scat_reg} + (opc_pkg::SCAT_SUM_W + 1)'(scatter_in);
        wasym_add = {wasym_reg[opc_pkg::WASYM_W-1], wasym_reg}
                  + {{(opc_pkg::WASYM_W + 1 - opc_pkg::MUL_P_W){wterm_in[opc_pkg::MUL_P_W-1]}},
                     wterm_in};

        // Clamp at the limits of each width instead of wrapping.
        depth_next = depth_add[opc_pkg::DEPTH_SUM_W] ? opc_pkg::DEPTH_SUM_MAX
                                                     : depth_add[opc_pkg::DEPTH_SUM_W-1:0];
        scat_next  = scat_add[opc_pkg::SCAT_SUM_W] ? opc_pkg::SCAT_SUM_MAX
                                                   : scat_add[opc_pkg::SCAT_SUM_W-1:0];
        if (wasym_add[opc_pkg::WASYM_W] != wasym_add[opc_pkg::WASYM_W-1])
        begin
            wasym_next = wasym_add[opc_pkg::WASYM_W] ? opc_pkg::WASYM_MIN : opc_pkg::WASYM_MAX;
        end
        else
        begin
            wasym_next = wasym_add[opc_pkg::WASYM_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg <= '0;
            scat_reg  <= '0;
            wasym_reg <= '0;
        end
        else if (ctl.clear)
        begin
            depth_reg <= '0;
            scat_reg  <= '0;
            wasym_reg <= '0;
        end
        else if (ctl.add)
        begin
            depth_reg <= depth_next;
            scat_reg  <= scat_next;
            wasym_reg <= wasym_next;
        end
    end

    assign depth_sum   = depth_reg;
    assign scatter_sum = scat_reg;
    assign wasym_sum   = signed'(wasym_reg);

endmodule

`default_nettype wire

>>> hw/rtl/opc_div.sv
// Restoring divider: one shared compare-subtract, one quotient bit a cycle.
`timescale 1ns / 1ps
`default_nettype none

module opc_div (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire opc_pkg::div_ctl_t                 ctl,
    input  wire logic [opc_pkg::REM_W-1:0]         rem_init,
    input  wire logic [opc_pkg::QUO_W-1:0]         low_init,
    input  wire logic [opc_pkg::SCAT_SUM_W-1:0]    divisor,
    output opc_pkg::div_stat_t                     stat,
    output logic      [opc_pkg::QUO_W-1:0]         quotient
);

    typedef enum logic [1:0] {
        D_IDLE,
        D_CHECK,
        D_STEP
    } dstate_t;

    dstate_t                           state_reg;
    logic [opc_pkg::REM_W-1:0]         rem_reg;
    logic [opc_pkg::QUO_W-1:0]         low_reg;
    logic [opc_pkg::SCAT_SUM_W-1:0]    div_reg;
    logic [opc_pkg::QUO_W-1:0]         quo_reg;
    logic [opc_pkg::DIV_CNT_W-1:0]     cnt_reg;
    logic                              done_reg;
    logic                              ovf_reg;

    logic [opc_pkg::REM_W-1:0]         trial;
    logic [opc_pkg::REM_W:0]           diff;
    logic                              ge;

    // The check pass compares the high part alone: a hit there means the
    // quotient does not fit in the bits asked for.
    always_comb
    begin
        trial = (state_reg == D_CHECK) ? rem_reg
                                       : {rem_reg[opc_pkg::REM_W-2:0], low_reg[opc_pkg::QUO_W-1]};
        diff  = {1'b0, trial} - (opc_pkg::REM_W + 1)'(div_reg);
        ge    = ~diff[opc_pkg::REM_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            rem_reg   <= '0;
            low_reg   <= '0;
            div_reg   <= '0;
            quo_reg   <= '0;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                D_IDLE:
                begin
                    if (ctl.start)
                    begin
                        rem_reg   <= rem_init;
                        low_reg   <= low_init;
                        div_reg   <= divisor;
                        cnt_reg   <= ctl.nbits;
                        quo_reg   <= '0;
                        ovf_reg   <= 1'b0;
                        state_reg <= D_CHECK;
                    end
                end
                D_CHECK:
                begin
                    ovf_reg <= ge;
                    if (ge)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= D_IDLE;
                    end
                    else
                    begin
                        state_reg <= D_STEP;
                    end
                end
                D_STEP:
                begin
                    rem_reg <= ge ? diff[opc_pkg::REM_W-1:0] : trial;
                    low_reg <= {low_reg[opc_pkg::QUO_W-2:0], 1'b0};
                    quo_reg <= {quo_reg[opc_pkg::QUO_W-2:0], ge};
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == opc_pkg::DIV_CNT_W'(1))
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= D_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= D_IDLE;
                end
            endcase
        end
    end

    assign stat.done     = done_reg;
    assign stat.overflow = ovf_reg;
    assign quotient      = quo_reg;

endmodule

`default_nettype wire

>>> hw/rtl/optical_property_combiner.sv
// Top level of the optical property combiner: stream ports and sequencer.
`timescale 1ns / 1ps
`default_nettype none

// Merges the optical depth, single-scatter albedo and asymmetry factor of
// the mechanisms at one spectral point. Each input transaction is one
// mechanism; the transaction with tlast high closes the point and yields one
// output transaction holding the saturated total depth, the total albedo and
// the total asymmetry, with a status code in tuser (zero depth sum, zero
// scattering sum or depth saturated force the affected values to zero or to
// full scale). For every mechanism one shared 26x18 multiplier forms the
// scattering term and then the weighted asymmetry term in two passes, and a
// further state adds them into the saturating sums. The final mechanism then
// runs one restoring divider that delivers one quotient bit a cycle: first
// the albedo division (17 quotient bits), then the asymmetry division (16
// bits), each skipped when its divisor is zero and cut short when the
// quotient overflows; a last state hands the result to the output register
// once that register is free. s_axis_tready is high only between
// mechanisms. The output register frees the input side: the next point is
// accepted while a result still waits for m_axis_tready.

module optical_property_combiner (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // [23:0] optical_depth, [40:24] albedo, [57:41] asymmetry, [63:58] zero
    input  wire logic [opc_pkg::TDATA_W-1:0]   s_axis_tdata,
    input  wire logic                          s_axis_tlast,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // [23:0] total_depth, [40:24] total_albedo, [57:41] total_asymmetry,
    // [63:58] zero
    output logic      [opc_pkg::TDATA_W-1:0]   m_axis_tdata,
    // [1:0] status
    output logic      [opc_pkg::STATUS_W-1:0]  m_axis_tuser
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_SCAT,
        S_MUL_ASYM,
        S_ACC,
        S_DIV1_START,
        S_DIV1_WAIT,
        S_DIV2_START,
        S_DIV2_WAIT,
        S_FIN
    } state_t;

    state_t                                    state_reg;
    logic        [opc_pkg::DEPTH_IN_W-1:0]     tau_reg;
    logic        [opc_pkg::ALBEDO_W-1:0]       alb_reg;
    logic        [opc_pkg::ASYM_W-1:0]         asym_reg;
    logic                                      last_reg;
    logic        [opc_pkg::SCAT_TERM_W-1:0]    scat_reg;
    logic        [opc_pkg::QUO_W-1:0]          talb_reg;
    logic        [opc_pkg::ASYM_W-1:0]         tasym_reg;
    logic        [opc_pkg::TDATA_W-1:0]        m_tdata_reg;
    logic        [opc_pkg::STATUS_W-1:0]       m_tuser_reg;
    logic                                      m_valid_reg;

    logic signed [opc_pkg::MUL_A_W-1:0]        mul_a;
    logic signed [opc_pkg::MUL_B_W-1:0]        mul_b;
    logic                                      mul_load;
    logic signed [opc_pkg::MUL_P_W-1:0]        product;

    opc_pkg::acc_ctl_t                         acc_ctl;
    logic        [opc_pkg::DEPTH_SUM_W-1:0]    depth_sum;
    logic        [opc_pkg::SCAT_SUM_W-1:0]     scatter_sum;
    logic signed [opc_pkg::WASYM_W-1:0]        wasym_sum;

    opc_pkg::div_ctl_t                         div_ctl;
    opc_pkg::div_stat_t                        div_stat;
    logic        [opc_pkg::REM_W-1:0]          div_rem_init;
    logic        [opc_pkg::QUO_W-1:0]          div_low_init;
    logic        [opc_pkg::SCAT_SUM_W-1:0]     div_divisor;
    logic        [opc_pkg::QUO_W-1:0]          quotient;

    logic                                      in_accept;
    logic                                      out_free;
    logic                                      out_load;
    logic                                      depth_zero;
    logic                                      scatter_zero;
    logic                                      depth_over;
    logic                                      wasym_neg;
    logic        [opc_pkg::WASYM_W-1:0]        wasym_mag;
    logic        [opc_pkg::QUO_W-1:0]          alb_clamped;
    logic        [opc_pkg::QUO_W-1:0]          asym_mag;
    logic        [opc_pkg::DEPTH_IN_W-1:0]     tdepth;
    opc_pkg::status_t                          status;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;
    assign out_load      = (state_reg == S_FIN) && out_free;

    // Shared multiplier: tau * albedo first, then scattering term * asymmetry.
    always_comb
    begin
        if (state_reg == S_MUL_ASYM)
        begin
            mul_a = signed'({1'b0, product[opc_pkg::SCAT_TERM_W+15:16]});
            mul_b = signed'({asym_reg[opc_pkg::ASYM_W-1], asym_reg});
        end
        else
        begin
            mul_a = signed'({2'b00, tau_reg});
            mul_b = signed'({1'b0, alb_reg});
        end
        mul_load = (state_reg == S_MUL_SCAT) || (state_reg == S_MUL_ASYM);
    end

    opc_mult u_mult (
        .clk     (clk),
        .load    (mul_load),
        .a       (mul_a),
        .b       (mul_b),
        .product (product)
    );

    assign acc_ctl.add   = (state_reg == S_ACC);
    assign acc_ctl.clear = out_load;

    opc_accum u_accum (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (acc_ctl),
        .depth_in    (tau_reg),
        .scatter_in  (scat_reg),
        .wterm_in    (product),
        .depth_sum   (depth_sum),
        .scatter_sum (scatter_sum),
        .wasym_sum   (wasym_sum)
    );

    always_comb
    begin
        depth_zero   = (depth_sum == '0);
        scatter_zero = (scatter_sum == '0);
        depth_over   = |depth_sum[opc_pkg::DEPTH_SUM_W-1:opc_pkg::DEPTH_IN_W];
        wasym_neg    = wasym_sum[opc_pkg::WASYM_W-1];
        // The most negative sum negates to 2^47, which still fits unsigned.
        wasym_mag    = wasym_neg ? (~unsigned'(wasym_sum) + 1'b1) : unsigned'(wasym_sum);
    end

    // Albedo: (scatter << 16) / depth, quotient bits 16..0; the high part of
    // the dividend is scatter >> 1 and the low part holds scatter bit 0.
    // Asymmetry: |wasym| / scatter, quotient bits 15..0.
    always_comb
    begin
        if (state_reg == S_DIV2_START)
        begin
            div_rem_init  = wasym_mag[opc_pkg::WASYM_W-1:opc_pkg::WASYM_W-opc_pkg::REM_W];
            div_low_init  = {wasym_mag[opc_pkg::QUO_W-2:0], 1'b0};
            div_divisor   = scatter_sum;
            div_ctl.nbits = opc_pkg::ASYM_QUO_BITS;
            div_ctl.start = !scatter_zero;
        end
        else
        begin
            div_rem_init  = opc_pkg::REM_W'(scatter_sum[opc_pkg::SCAT_SUM_W-1:1]);
            div_low_init  = {scatter_sum[0], {(opc_pkg::QUO_W-1){1'b0}}};
            div_divisor   = opc_pkg::SCAT_SUM_W'(depth_sum);
            div_ctl.nbits = opc_pkg::ALB_QUO_BITS;
            div_ctl.start = (state_reg == S_DIV1_START) && !depth_zero;
        end
    end

    opc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (div_ctl),
        .rem_init (div_rem_init),
        .low_init (div_low_init),
        .divisor  (div_divisor),
        .stat     (div_stat),
        .quotient (quotient)
    );

    always_comb
    begin
        alb_clamped = (div_stat.overflow || (quotient > opc_pkg::ALBEDO_ONE))
                    ? opc_pkg::ALBEDO_ONE : quotient;
        asym_mag    = (div_stat.overflow || (quotient > opc_pkg::ASYM_ONE))
                    ? opc_pkg::ASYM_ONE : quotient;
        tdepth      = depth_over ? opc_pkg::OUT_DEPTH_MAX : depth_sum[opc_pkg::DEPTH_IN_W-1:0];
        if (depth_zero)
        begin
            status = opc_pkg::ST_ZERO_DEPTH;
        end
        else if (scatter_zero)
        begin
            status = opc_pkg::ST_ZERO_SCATTER;
        end
        else if (depth_over)
        begin
            status = opc_pkg::ST_DEPTH_SAT;
        end
        else
        begin
            status = opc_pkg::ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            tau_reg     <= '0;
            alb_reg     <= '0;
            asym_reg    <= '0;
            last_reg    <= 1'b0;
            scat_reg    <= '0;
            talb_reg    <= '0;
            tasym_reg   <= '0;
            m_tdata_reg <= '0;
            m_tuser_reg <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            // Raise valid when a result is handed over; drop it once taken.
            if (out_load)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_accept)
                    begin
                        tau_reg   <= s_axis_tdata[opc_pkg::DEPTH_IN_W-1:0];
                        alb_reg   <= s_axis_tdata[opc_pkg::DEPTH_IN_W+opc_pkg::ALBEDO_W-1:
                                                  opc_pkg::DEPTH_IN_W];
                        asym_reg  <= s_axis_tdata[opc_pkg::DEPTH_IN_W+opc_pkg::ALBEDO_W+
                                                  opc_pkg::ASYM_W-1:
                                                  opc_pkg::DEPTH_IN_W+opc_pkg::ALBEDO_W];
                        last_reg  <= s_axis_tlast;
                        state_reg <= S_MUL_SCAT;
                    end
                end
                S_MUL_SCAT:
                begin
                    state_reg <= S_MUL_ASYM;
                end
                S_MUL_ASYM:
                begin
                    // Hold the scattering term while the product turns into
                    // the weighted asymmetry term.
                    scat_reg  <= product[opc_pkg::SCAT_TERM_W+15:16];
                    state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    state_reg <= last_reg ? S_DIV1_START : S_IDLE;
                end
                S_DIV1_START:
                begin
                    if (depth_zero)
                    begin
                        talb_reg  <= '0;
                        state_reg <= S_DIV2_START;
                    end
                    else
                    begin
                        state_reg <= S_DIV1_WAIT;
                    end
                end
                S_DIV1_WAIT:
                begin
                    if (div_stat.done)
                    begin
                        talb_reg  <= alb_clamped;
                        state_reg <= S_DIV2_START;
                    end
                end
                S_DIV2_START:
                begin
                    if (scatter_zero)
                    begin
                        tasym_reg <= '0;
                        state_reg <= S_FIN;
                    end
                    else
                    begin
                        state_reg <= S_DIV2_WAIT;
                    end
                end
                S_DIV2_WAIT:
                begin
                    if (div_stat.done)
                    begin
                        tasym_reg <= wasym_neg ? (~asym_mag + 1'b1) : asym_mag;
                        state_reg <= S_FIN;
                    end
                end
                S_FIN:
                begin
                    // Hold here until the output register is free.
                    if (out_free)
                    begin
                        m_tdata_reg <= {{(opc_pkg::TDATA_W - opc_pkg::DEPTH_IN_W
                                          - opc_pkg::QUO_W - opc_pkg::ASYM_W){1'b0}},
                                        tasym_reg, talb_reg, tdepth};
                        m_tuser_reg <= status;
                        state_reg   <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_tdata_reg;
    assign m_axis_tuser  = m_tuser_reg;

endmodule

`default_nettype wire

>>> hw/rtl/opc_checker.sv
// Port-level assertions for the optical property combiner, bound to the top.
`timescale 1ns / 1ps
`default_nettype none
`include "optical_property_combiner_defines.svh"

module opc_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          s_axis_tvalid,
    input wire logic                          s_axis_tready,
    input wire logic                          m_axis_tvalid,
    input wire logic                          m_axis_tready,
    input wire logic [opc_pkg::TDATA_W-1:0]   m_axis_tdata,
    input wire logic [opc_pkg::STATUS_W-1:0]  m_axis_tuser
);

    // After each accepted mechanism, s_axis_tready is low in the next cycle.
    `OPC_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    // Zero depth sum: all three values are zero.
    `OPC_ASSERT_SAME(a_zero_depth_fields,
        m_axis_tvalid && (m_axis_tuser == opc_pkg::ST_ZERO_DEPTH),
        m_axis_tdata[57:0] == 58'd0)

    // Zero scattering sum: asymmetry is zero.
    `OPC_ASSERT_SAME(a_zero_scatter_asym,
        m_axis_tvalid && (m_axis_tuser == opc_pkg::ST_ZERO_SCATTER),
        m_axis_tdata[57:41] == 17'd0)

    // Saturated depth: total depth at full scale, albedo still clamped.
    `OPC_ASSERT_SAME(a_depth_sat_fields,
        m_axis_tvalid && (m_axis_tuser == opc_pkg::ST_DEPTH_SAT),
        (m_axis_tdata[23:0] == 24'hFFFFFF) && (m_axis_tdata[40:24] <= 17'd65536))

    // A stalled result holds.
    `OPC_ASSERT_NEXT(a_out_stall_hold, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

endmodule

bind optical_property_combiner opc_checker u_opc_checker (.*);

`default_nettype wire
